// ===== hw/rtl/soq_pkg.sv =====
// ----------------------------------------------------------------------------
// soq_pkg
// shared types and constants for the sorted order queue
// ----------------------------------------------------------------------------
package soq_pkg;

  localparam int DEPTH      = 16;
  localparam int FLOOR_BITS = 4;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // register index taken from the word address
  localparam logic REG_MAX_PRIORITY  = 1'b0;
  localparam logic REG_MAX_DIRECTION = 1'b1;

  typedef enum logic [1:0] {
    REQ_INSERT    = 2'd0,
    REQ_DELETE    = 2'd1,
    REQ_DEL_FLOOR = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_code_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_INVALID  = 3'd2,
    ST_FULL     = 3'd3,
    ST_REMOVED  = 3'd4
  } status_t;

  typedef struct packed {
    req_code_t   req_type;
    logic [1:0]  order_priority;
    logic [1:0]  order_direction;
    logic [3:0]  order_floor;
  } soq_req_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  entry_count;
    logic        head_valid;
    logic [1:0]  head_priority;
    logic [1:0]  head_direction;
    logic [3:0]  head_floor;
  } soq_res_t;

  // sort key: priority, then direction, then floor
  typedef struct packed {
    logic [1:0]            pri;
    logic [1:0]            dir;
    logic [FLOOR_BITS-1:0] flr;
  } key_t;

endpackage

// ===== hw/rtl/sorted_order_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_order_queue
// sorted order table with duplicate suppression and removal requests
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown on result for the single cycle in which done is high,
// and the receiver cannot stall it. The table lives in a simple dual-port
// memory (one read, one write per cycle) walked by a small sequencer, so the
// time per transaction is set by that one read port. An insert scans the
// table for its place; one that lands inside the table then shifts the
// entries above that point up by one slot before the new order is written.
// A duplicate or full insert ends after the scan. A delete or floor purge
// compacts the table in one pass, and a clear or rejected insert goes
// straight to the head read. The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_order_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  soq_pkg::soq_req_t             req,
  output logic                          busy,
  output logic                          done,
  output soq_pkg::soq_res_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [soq_pkg::ADDR_W-1:0]    paddr,
  input  logic [soq_pkg::DATA_W-1:0]    pwdata,
  output logic [soq_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import soq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_PUT, S_COMPACT, S_HEAD, S_DONE
  } state_t;

  state_t            state;
  logic [1:0]        max_priority;
  logic [1:0]        max_direction;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  acc;
  logic              issue;
  logic              pend;
  logic [IDX_W-1:0]  pidx;
  logic              dup;
  logic              dropped;
  req_code_t         req_code;
  key_t              key;
  status_t           status;

  key_t              order_mem [DEPTH];
  key_t              rdata;
  logic              ren;
  logic [IDX_W-1:0]  raddr;
  logic              wen;
  logic [IDX_W-1:0]  waddr;
  key_t              wdata;

  key_t              in_key;
  logic              drop;
  logic              hit;
  logic              less;
  logic              dup_now;
  logic [CNT_W-1:0]  pos_now;
  logic              reg_sel;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_MAX_PRIORITY) begin
      prdata[1:0] = max_priority;
    end else begin
      prdata[1:0] = max_direction;
    end
  end

  assign busy = (state != S_IDLE);

  assign in_key.pri = req.order_priority;
  assign in_key.dir = req.order_direction;
  assign in_key.flr = FLOOR_BITS'(req.order_floor);

  assign hit     = (rdata == key);
  assign less    = (rdata < key);
  assign dup_now = dup | hit;
  assign pos_now = acc + CNT_W'(less);
  assign drop    = (req_code == REQ_DEL_FLOOR) ? (rdata.flr == key.flr) : (hit && !dropped);

  // memory access control
  always_comb begin
    ren   = 1'b0;
    raddr = ptr[IDX_W-1:0];
    wen   = 1'b0;
    waddr = acc[IDX_W-1:0];
    wdata = rdata;
    unique case (state)
      S_SCAN, S_COMPACT: begin
        ren = issue;
        if (state == S_COMPACT) begin
          wen = pend && !drop;
        end
      end
      S_SHIFT: begin
        ren   = issue;
        wen   = pend;
        waddr = pidx + IDX_W'(1);
      end
      S_PUT: begin
        wen   = 1'b1;
        wdata = key;
      end
      S_HEAD: begin
        ren   = 1'b1;
        raddr = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      order_mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= order_mem[raddr];
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_priority  <= 2'd1;
      max_direction <= 2'd1;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == REG_MAX_PRIORITY) begin
        max_priority <= pwdata[1:0];
      end else begin
        max_direction <= pwdata[1:0];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      issue <= 1'b0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_code <= req.req_type;
            key      <= in_key;
            ptr      <= '0;
            acc      <= '0;
            dup      <= 1'b0;
            dropped  <= 1'b0;
            issue    <= 1'b1;
            status   <= ST_REMOVED;
            unique case (req.req_type)
              REQ_INSERT: begin
                if (req.order_priority > max_priority ||
                    req.order_direction > max_direction) begin
                  status <= ST_INVALID;
                  state  <= S_HEAD;
                end else if (count == '0) begin
                  state <= S_PUT;
                end else begin
                  state <= S_SCAN;
                end
              end
              REQ_DELETE, REQ_DEL_FLOOR: begin
                state <= (count == '0) ? S_HEAD : S_COMPACT;
              end
              REQ_CLEAR: begin
                count <= '0;
                state <= S_HEAD;
              end
            endcase
          end
        end
        S_SCAN, S_COMPACT: begin
          if (issue) begin
            pend <= 1'b1;
            pidx <= ptr[IDX_W-1:0];
            ptr  <= ptr + CNT_W'(1);
            if (ptr + CNT_W'(1) == count) begin
              issue <= 1'b0;
            end
          end
          if (pend && state == S_SCAN) begin
            dup <= dup_now;
            acc <= pos_now;
            if (!issue) begin
              if (dup_now) begin
                status <= ST_DUPLICATE;
                state  <= S_HEAD;
              end else if (count == CNT_W'(DEPTH)) begin
                status <= ST_FULL;
                state  <= S_HEAD;
              end else if (pos_now == count) begin
                state <= S_PUT;
              end else begin
                ptr   <= count - CNT_W'(1);
                issue <= 1'b1;
                state <= S_SHIFT;
              end
            end
          end
          if (pend && state == S_COMPACT) begin
            if (drop) begin
              dropped <= 1'b1;
            end else begin
              acc <= acc + CNT_W'(1);
            end
            if (!issue) begin
              count <= acc + CNT_W'(!drop);
              state <= S_HEAD;
            end
          end
        end
        S_SHIFT: begin
          if (issue) begin
            pend <= 1'b1;
            pidx <= ptr[IDX_W-1:0];
            if (ptr == acc) begin
              issue <= 1'b0;
            end else begin
              ptr <= ptr - CNT_W'(1);
            end
          end
          if (pend && !issue) begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          count  <= count + CNT_W'(1);
          status <= ST_INSERTED;
          state  <= S_HEAD;
        end
        S_HEAD: begin
          issue <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: begin
          done                 <= 1'b1;
          result.status        <= status;
          result.entry_count   <= 5'(count);
          result.head_valid    <= (count != '0);
          if (count != '0) begin
            result.head_priority  <= rdata.pri;
            result.head_direction <= rdata.dir;
            result.head_floor     <= 4'(rdata.flr);
          end else begin
            result.head_priority  <= '0;
            result.head_direction <= '0;
            result.head_floor     <= '0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/soq_checker.sv =====
// ----------------------------------------------------------------------------
// soq_checker
// port-level checks for the sorted order queue
// ----------------------------------------------------------------------------
module soq_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  soq_pkg::soq_res_t  result
);
  import soq_pkg::*;

  // every accepted transaction raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result only ends a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside end of transaction");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.entry_count <= 5'(DEPTH))
    else $error("entry count above table depth");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    done && !result.head_valid |->
      result.head_priority == '0 && result.head_direction == '0 &&
      result.head_floor == '0)
    else $error("empty table reports a head order");

endmodule

bind sorted_order_queue soq_checker u_soq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
